/* hw/rtl/sdu_pkg.sv */
// ----------------------------------------------------------------------------
// sdu_pkg
// Shared types, character codes and helpers of the SMTP data dot unstuffer.
// ----------------------------------------------------------------------------
package sdu_pkg;

  // Character codes seen by the matcher
  localparam logic [7:0] CharCr  = 8'h0D;
  localparam logic [7:0] CharLf  = 8'h0A;
  localparam logic [7:0] CharDot = 8'h2E;

  // Reset value of the chunk length register
  localparam logic [15:0] ChunkLimitReset = 16'd30000;

  // Default depth of the command queue between front and back
  localparam int unsigned SduQueueDepth = 4;

  // Line matcher state
  typedef enum logic [2:0] {
    MatchIdle,
    MatchCr,
    MatchCrLf,
    MatchDot,
    MatchDotCr
  } match_state_e;

  // What the back end has to emit for one input byte
  typedef enum logic [2:0] {
    OpByte,       // the byte itself
    OpDot,        // a single dot (doubled dot collapsed)
    OpDotByte,    // held dot, then the byte
    OpDotCrByte,  // held dot and CR, then the byte
    OpMsgEnd      // terminator marker, no byte
  } emit_op_e;

  typedef struct packed {
    emit_op_e    op;
    logic [7:0]  data;
    logic        clr;   // clear chunk count before the first result
  } emit_cmd_t;

  // Number of results an operation expands to
  function automatic logic [1:0] run_len(emit_op_e op);
    logic [1:0] len;
    case (op)
      OpDotByte:   len = 2'd2;
      OpDotCrByte: len = 2'd3;
      default:     len = 2'd1;
    endcase
    return len;
  endfunction

endpackage

/* hw/rtl/sdu_ifs.sv */
// ----------------------------------------------------------------------------
// sdu_ifs
// Valid/ready channel interfaces: input bytes, results and chunk limit writes.
// ----------------------------------------------------------------------------
interface sdu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_message;

  modport source (output valid, data_byte, new_message, input ready);
  modport sink   (input valid, data_byte, new_message, output ready);
endinterface

interface sdu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       chunk_end;
  logic       message_end;
  logic       last_of_run;

  modport source (output valid, out_byte, byte_valid, chunk_end, message_end,
                  last_of_run, input ready);
  modport sink   (input valid, out_byte, byte_valid, chunk_end, message_end,
                  last_of_run, output ready);
endinterface

interface sdu_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] chunk_limit;

  modport source (output valid, chunk_limit, input ready);
  modport sink   (input valid, chunk_limit, output ready);
endinterface

/* hw/rtl/sdu_front.sv */
// ----------------------------------------------------------------------------
// sdu_front
// Accepts input bytes, runs the CR LF dot matcher and pushes one emit
// command per byte that causes results.
// ----------------------------------------------------------------------------
module sdu_front
  import sdu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sdu_in_if.sink     in_i,
  input  logic       q_full_i,
  output logic       push_o,
  output emit_cmd_t  cmd_o
);

  match_state_e state_q, state_d;
  match_state_e cur_state;
  match_state_e after_state;
  logic [7:0]   c;
  logic         take;

  assign in_i.ready = ~q_full_i;
  assign take       = in_i.valid & in_i.ready;
  assign c          = in_i.data_byte;

  // state after emitting c
  assign after_state = (c == CharCr) ? MatchCr : MatchIdle;
  // a new message restarts the matcher before this byte
  assign cur_state   = in_i.new_message ? MatchIdle : state_q;

  // Next state and command
  always_comb begin
    state_d    = state_q;
    push_o     = 1'b0;
    cmd_o.op   = OpByte;
    cmd_o.data = c;
    cmd_o.clr  = in_i.new_message;
    if (take) begin
      case (cur_state)
        MatchCr: begin
          push_o  = 1'b1;
          state_d = (c == CharLf) ? MatchCrLf : after_state;
        end
        MatchCrLf: begin
          if (c == CharDot) begin
            state_d = MatchDot;
          end else begin
            push_o  = 1'b1;
            state_d = after_state;
          end
        end
        MatchDot: begin
          if (c == CharCr) begin
            state_d = MatchDotCr;
          end else if (c == CharDot) begin
            push_o   = 1'b1;
            cmd_o.op = OpDot;
            state_d  = MatchIdle;
          end else begin
            push_o   = 1'b1;
            cmd_o.op = OpDotByte;
            state_d  = MatchIdle;
          end
        end
        MatchDotCr: begin
          push_o = 1'b1;
          if (c == CharLf) begin
            cmd_o.op = OpMsgEnd;
            state_d  = MatchIdle;
          end else begin
            cmd_o.op = OpDotCrByte;
            state_d  = after_state;
          end
        end
        default: begin
          push_o  = 1'b1;
          state_d = after_state;
        end
      endcase
    end
  end

  // Matcher state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MatchIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/sdu_cmd_queue.sv */
// ----------------------------------------------------------------------------
// sdu_cmd_queue
// Small FIFO of emit commands between the matcher and the emitter.
// ----------------------------------------------------------------------------
module sdu_cmd_queue
  import sdu_pkg::*;
#(
  parameter int unsigned Depth = SduQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  emit_cmd_t  cmd_i,
  output logic       full_o,
  input  logic       pop_i,
  output emit_cmd_t  head_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  emit_cmd_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* hw/rtl/sdu_back.sv */
// ----------------------------------------------------------------------------
// sdu_back
// Expands emit commands into result transfers, one per cycle while the
// output is ready, counts output bytes into chunks and holds the output register.
// ----------------------------------------------------------------------------
module sdu_back
  import sdu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] chunk_limit_i,
  input  emit_cmd_t   head_i,
  input  logic        empty_i,
  output logic        pop_o,
  sdu_out_if.source   out_o
);

  logic [1:0]  idx_q, idx_d;
  logic [15:0] count_q, count_d;
  logic        valid_q;
  logic [7:0]  byte_q;
  logic        bvalid_q, cend_q, mend_q, last_q;

  logic        load;
  logic        is_last;
  logic [7:0]  byte_sel;
  logic [15:0] base;
  logic [16:0] nxt;
  logic        hit;
  logic        bvalid_d, cend_d, mend_d;

  assign load    = ~empty_i & (~valid_q | out_o.ready);
  assign is_last = (idx_q == run_len(head_i.op) - 2'd1);
  assign pop_o   = load & is_last;
  assign idx_d   = is_last ? 2'd0 : idx_q + 2'd1;

  // Byte of the current result
  always_comb begin
    case (head_i.op)
      OpByte:      byte_sel = head_i.data;
      OpDot:       byte_sel = CharDot;
      OpDotByte:   byte_sel = (idx_q == 2'd0) ? CharDot : head_i.data;
      OpDotCrByte: begin
        if (idx_q == 2'd0) begin
          byte_sel = CharDot;
        end else if (idx_q == 2'd1) begin
          byte_sel = CharCr;
        end else begin
          byte_sel = head_i.data;
        end
      end
      default:     byte_sel = 8'h00;
    endcase
  end

  // Chunk counting
  assign base = (head_i.clr && idx_q == 2'd0) ? 16'd0 : count_q;
  assign nxt  = {1'b0, base} + 17'd1;
  assign hit  = (nxt >= {1'b0, chunk_limit_i});

  always_comb begin
    if (head_i.op == OpMsgEnd) begin
      count_d  = 16'd0;
      bvalid_d = 1'b0;
      cend_d   = 1'b0;
      mend_d   = 1'b1;
    end else begin
      count_d  = hit ? 16'd0 : nxt[15:0];
      bvalid_d = 1'b1;
      cend_d   = hit;
      mend_d   = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      count_q <= 16'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= idx_d;
        count_q <= count_d;
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= byte_sel;
      bvalid_q <= bvalid_d;
      cend_q   <= cend_d;
      mend_q   <= mend_d;
      last_q   <= is_last;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.byte_valid  = bvalid_q;
  assign out_o.chunk_end   = cend_q;
  assign out_o.message_end = mend_q;
  assign out_o.last_of_run = last_q;

endmodule

/* hw/rtl/smtp_data_dot_unstuffer_unit.sv */
// ----------------------------------------------------------------------------
// smtp_data_dot_unstuffer_unit
// SMTP data phase dot unstuffer with CR LF dot CR LF end detection and
// output chunking.
//
//   channel  dir  payload                                        transfer
//   in_i     in   data_byte[7:0], new_message                    valid & ready
//   out_o    out  out_byte[7:0], byte_valid, chunk_end,
//                 message_end, last_of_run                       valid & ready
//   cfg_i    in   chunk_limit[15:0]                              valid & ready
//
// One input byte per cycle enters the matcher; a byte yields zero to three
// results, leaving the output register at one per cycle unless out_o stalls.
// The command queue (QueueDepth entries) absorbs multi-result bytes; input
// stalls only when it is full. The first result of a byte is offered once the
// byte has passed through the command queue and the output register.
// Reset clears matcher state, chunk count and queue; chunk_limit = 30000.
// cfg_i is always ready.
// ----------------------------------------------------------------------------
module smtp_data_dot_unstuffer_unit
  import sdu_pkg::*;
#(
  parameter int unsigned QueueDepth = SduQueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sdu_in_if.sink   in_i,
  sdu_out_if.source out_o,
  sdu_cfg_if.sink  cfg_i
);

  logic        q_push, q_pop, q_full, q_empty;
  emit_cmd_t   q_cmd, q_head;
  logic [15:0] chunk_limit_q;

  // Chunk length register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_limit_q <= ChunkLimitReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      chunk_limit_q <= cfg_i.chunk_limit;
    end
  end

  // Matcher
  sdu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .cmd_o    (q_cmd)
  );

  // Command queue
  sdu_cmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  // Emitter
  sdu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .chunk_limit_i (chunk_limit_q),
    .head_i        (q_head),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .out_o         (out_o)
  );

  // Checks
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("command popped from empty queue");

  a_msg_end_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.message_end) |->
      (out_o.last_of_run && !out_o.byte_valid && !out_o.chunk_end))
    else $error("message end result malformed");

endmodule
